// File: rtl/mp3s_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mp3s_pkg
// Shared constants and types of the strided 3x3 max pooling unit: register
// indexes, configuration word widths and the limits that the registers clamp to.
// -----------------------------------------------------------------------------
package mp3s_pkg;

  // configuration channel
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHANNEL_COUNT = 3'd0,
    CFG_IN_HEIGHT     = 3'd1,
    CFG_IN_WIDTH      = 3'd2,
    CFG_OUT_HEIGHT    = 3'd3,
    CFG_OUT_WIDTH     = 3'd4,
    CFG_POOL_STRIDE   = 3'd5
  } cfg_index_t;

  // register widths
  localparam int CHAN_W   = 11;
  localparam int DIM_W    = 7;
  localparam int STRIDE_W = 4;

  // counter widths
  localparam int ROW_W   = 6;
  localparam int PHASE_W = 3;
  localparam int CIDX_W  = 10;

  // clamp limits
  localparam logic [DIM_W-1:0]    MAX_HEIGHT   = 7'd64;
  localparam logic [STRIDE_W-1:0] MAX_STRIDE   = 4'd8;
  localparam logic [CHAN_W-1:0]   MAX_CHANNELS = 11'd1024;

endpackage

// File: rtl/mp3s_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mp3s interfaces
// Valid/ready channels of the pooling unit: the pixel input, the pooled result
// output and the configuration write channel.
// -----------------------------------------------------------------------------
interface mp3s_pix_if #(
  parameter int PIXEL_BITS = 8
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface mp3s_pool_if #(
  parameter int PIXEL_BITS = 8
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pooled_value;
  logic                         channel_done;
  logic                         frame_done;

  modport source (output valid, output pooled_value, output channel_done,
                  output frame_done, input ready);
  modport sink   (input valid, input pooled_value, input channel_done,
                  input frame_done, output ready);
endinterface

interface mp3s_cfg_if
  import mp3s_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/max_pool_3x3_strided_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// max_pool_3x3_strided_unit
// Strided 3x3 max pooling over a raster pixel stream, with a three-row line
// store held in column-wide words of a synchronous memory.
// -----------------------------------------------------------------------------
// The unit takes one pixel word per clock and keeps it up indefinitely while
// the result side keeps draining. A pixel's result, if it completes a window,
// reaches the four-word output queue by these steps: the line store is read on
// the accepting edge, the merged column words are captured into the stage 2
// registers, and the nine-way maximum is then written into the queue, from
// which the word can leave. Input is held off only when the queue plus the
// results still in the pipeline already amount to four words.
// No clearing pass follows reset; the line store is valid once written.
// Configure only while no pixel is in flight.
// -----------------------------------------------------------------------------
module max_pool_3x3_strided_unit
  import mp3s_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int PIXEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  mp3s_cfg_if.sink    cfg,
  mp3s_pix_if.sink    pix_in,
  mp3s_pool_if.source pool_out
);

  localparam int CW        = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int KW        = (CW > 7) ? CW + 1 : 8;
  localparam int WW        = 3 * PIXEL_BITS;
  localparam int OUT_DEPTH = 4;
  localparam int QP_W      = 2;
  localparam int QC_W      = 3;

  typedef logic signed [PIXEL_BITS-1:0] pix_t;
  typedef logic [WW-1:0]                word_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0]   channel_count;
  logic [DIM_W-1:0]    in_height;
  logic [DIM_W-1:0]    in_width;
  logic [DIM_W-1:0]    out_height;
  logic [DIM_W-1:0]    out_width;
  logic [STRIDE_W-1:0] pool_stride;

  assign cfg.ready = 1'b1;

  // take a register write; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHAN_W'(1);
      in_height     <= DIM_W'(3);
      in_width      <= DIM_W'(3);
      out_height    <= DIM_W'(1);
      out_width     <= DIM_W'(1);
      pool_stride   <= STRIDE_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_CHANNEL_COUNT: channel_count <= cfg.data[CHAN_W-1:0];
        CFG_IN_HEIGHT:     in_height     <= cfg.data[DIM_W-1:0];
        CFG_IN_WIDTH:      in_width      <= cfg.data[DIM_W-1:0];
        CFG_OUT_HEIGHT:    out_height    <= cfg.data[DIM_W-1:0];
        CFG_OUT_WIDTH:     out_width     <= cfg.data[DIM_W-1:0];
        CFG_POOL_STRIDE:   pool_stride   <= cfg.data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to their usable ranges
  logic [KW-1:0]       eff_w;
  logic [DIM_W-1:0]    eff_h;
  logic [STRIDE_W-1:0] eff_s;
  logic [CHAN_W-1:0]   eff_c;

  always_comb begin
    if (in_width == '0)                       eff_w = KW'(1);
    else if (KW'(in_width) > KW'(MAX_WIDTH))  eff_w = KW'(MAX_WIDTH);
    else                                      eff_w = KW'(in_width);

    if (in_height == '0)                      eff_h = DIM_W'(1);
    else if (in_height > MAX_HEIGHT)          eff_h = MAX_HEIGHT;
    else                                      eff_h = in_height;

    if (pool_stride == '0)                    eff_s = STRIDE_W'(1);
    else if (pool_stride > MAX_STRIDE)        eff_s = MAX_STRIDE;
    else                                      eff_s = pool_stride;

    if (channel_count == '0)                  eff_c = CHAN_W'(1);
    else if (channel_count > MAX_CHANNELS)    eff_c = MAX_CHANNELS;
    else                                      eff_c = channel_count;
  end

  // ---------------------------------------------------------------------------
  // position counters
  // ---------------------------------------------------------------------------
  logic [CW-1:0]      in_col, in_col_next;
  logic [ROW_W-1:0]   in_row, in_row_next;
  logic [1:0]         row_lane, row_lane_next;
  logic [PHASE_W-1:0] col_phase, col_phase_next;
  logic [PHASE_W-1:0] row_phase, row_phase_next;
  logic [DIM_W-1:0]   out_col, out_col_next;
  logic [DIM_W-1:0]   out_row, out_row_next;
  logic [CIDX_W-1:0]  channel_index, channel_index_next;

  logic          accept;
  logic [CW-1:0] col;
  logic          row_active, col_active, win_hit;
  logic          chan_last, frame_last;

  assign accept = pix_in.valid && pix_in.ready;

  always_comb begin
    col = (KW'(in_col) < eff_w) ? in_col : CW'(eff_w - KW'(1));

    row_active = (in_row >= ROW_W'(2)) && (row_phase == '0) && (out_row < out_height);
    col_active = (KW'(in_col) >= KW'(2)) && (col_phase == '0) && (out_col < out_width);
    win_hit    = row_active && col_active;

    chan_last  = ((DIM_W+1)'(out_row) + 1'b1 == (DIM_W+1)'(out_height)) &&
                 ((DIM_W+1)'(out_col) + 1'b1 == (DIM_W+1)'(out_width));
    frame_last = chan_last && (CHAN_W'(channel_index) + 1'b1 >= eff_c);

    in_col_next        = in_col + 1'b1;
    in_row_next        = in_row;
    row_lane_next      = row_lane;
    col_phase_next     = col_phase;
    row_phase_next     = row_phase;
    out_col_next       = win_hit ? out_col + 1'b1 : out_col;
    out_row_next       = out_row;
    channel_index_next = channel_index;

    // step the column phase once the first window column is reached
    if (KW'(in_col) >= KW'(2)) begin
      if (STRIDE_W'(col_phase) + 1'b1 >= eff_s) col_phase_next = '0;
      else                                      col_phase_next = col_phase + 1'b1;
    end

    // wrap at row end
    if (KW'(in_col) + 1'b1 >= eff_w) begin
      in_col_next    = '0;
      col_phase_next = '0;
      out_col_next   = '0;
      if (row_active) out_row_next = out_row + 1'b1;
      if (in_row >= ROW_W'(2)) begin
        if (STRIDE_W'(row_phase) + 1'b1 >= eff_s) row_phase_next = '0;
        else                                      row_phase_next = row_phase + 1'b1;
      end
      if (DIM_W'(in_row) + 1'b1 >= eff_h) begin
        in_row_next    = '0;
        row_lane_next  = '0;
        row_phase_next = '0;
        out_row_next   = '0;
        if (CHAN_W'(channel_index) + 1'b1 >= eff_c) channel_index_next = '0;
        else                                        channel_index_next = channel_index + 1'b1;
      end else begin
        in_row_next   = in_row + 1'b1;
        row_lane_next = (row_lane == 2'd2) ? 2'd0 : row_lane + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col        <= '0;
      in_row        <= '0;
      row_lane      <= '0;
      col_phase     <= '0;
      row_phase     <= '0;
      out_col       <= '0;
      out_row       <= '0;
      channel_index <= '0;
    end else if (accept) begin
      in_col        <= in_col_next;
      in_row        <= in_row_next;
      row_lane      <= row_lane_next;
      col_phase     <= col_phase_next;
      row_phase     <= row_phase_next;
      out_col       <= out_col_next;
      out_row       <= out_row_next;
      channel_index <= channel_index_next;
    end
  end

  // ---------------------------------------------------------------------------
  // line store: one word per column, one lane per row modulo three
  // ---------------------------------------------------------------------------
  word_t mem_a [MAX_WIDTH];
  word_t mem_b [MAX_WIDTH];

  logic [CW-1:0] addr_p1, addr_p2;
  assign addr_p1 = col - CW'(1);
  assign addr_p2 = col - CW'(2);

  // stage 1 control and payload
  logic          s1_valid;
  logic          s1_res;
  logic          s1_chan_done, s1_frame_done;
  pix_t          s1_pixel;
  logic [CW-1:0] s1_col;
  logic [1:0]    s1_lane;
  word_t         rd_cur, rd_p1, rd_p2;
  word_t         fwd_word;
  logic          hit_cur, hit_p1, hit_p2;
  word_t         s1_word, s1_p1, s1_p2, cur_word;

  // read the three window columns as the pixel is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_cur <= mem_a[col];
      rd_p1  <= mem_a[addr_p1];
      rd_p2  <= mem_b[addr_p2];
    end
  end

  // write back the merged column word
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem_a[s1_col] <= s1_word;
      mem_b[s1_col] <= s1_word;
    end
  end

  // forward a write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_word      <= s1_word;
      hit_cur       <= s1_valid && (s1_col == col);
      hit_p1        <= s1_valid && (s1_col == addr_p1);
      hit_p2        <= s1_valid && (s1_col == addr_p2);
      s1_pixel      <= pix_in.pixel;
      s1_col        <= col;
      s1_lane       <= row_lane;
      s1_chan_done  <= chan_last;
      s1_frame_done <= frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_res   <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_res   <= accept && win_hit;
    end
  end

  // merge the new pixel into its row lane
  always_comb begin
    cur_word = hit_cur ? fwd_word : rd_cur;
    s1_p1    = hit_p1 ? fwd_word : rd_p1;
    s1_p2    = hit_p2 ? fwd_word : rd_p2;
    s1_word  = cur_word;
    case (s1_lane)
      2'd0:    s1_word[0*PIXEL_BITS +: PIXEL_BITS] = s1_pixel;
      2'd1:    s1_word[1*PIXEL_BITS +: PIXEL_BITS] = s1_pixel;
      2'd2:    s1_word[2*PIXEL_BITS +: PIXEL_BITS] = s1_pixel;
      default: s1_word = cur_word;
    endcase
  end

  // ---------------------------------------------------------------------------
  // stage 2: window maximum
  // ---------------------------------------------------------------------------
  logic  s2_valid;
  logic  s2_chan_done, s2_frame_done;
  word_t s2_w0, s2_w1, s2_w2;
  pix_t  s2_max;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid && s1_res;
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_res) begin
      s2_w0         <= s1_word;
      s2_w1         <= s1_p1;
      s2_w2         <= s1_p2;
      s2_chan_done  <= s1_chan_done;
      s2_frame_done <= s1_frame_done;
    end
  end

  always_comb begin
    pix_t v;
    s2_max = $signed(s2_w0[PIXEL_BITS-1:0]);
    for (int l = 0; l < 3; l++) begin
      v = $signed(s2_w0[l*PIXEL_BITS +: PIXEL_BITS]);
      if (v > s2_max) s2_max = v;
      v = $signed(s2_w1[l*PIXEL_BITS +: PIXEL_BITS]);
      if (v > s2_max) s2_max = v;
      v = $signed(s2_w2[l*PIXEL_BITS +: PIXEL_BITS]);
      if (v > s2_max) s2_max = v;
    end
  end

  // ---------------------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------------------
  pix_t            q_value [OUT_DEPTH];
  logic            q_chan  [OUT_DEPTH];
  logic            q_frame [OUT_DEPTH];
  logic [QP_W-1:0] q_wr, q_rd;
  logic [QC_W-1:0] q_count;
  logic            q_push, q_pop;
  logic [QC_W-1:0] pending;

  assign q_push = s2_valid;
  assign q_pop  = pool_out.valid && pool_out.ready;

  // hold input while in-flight results could overrun the queue
  assign pending      = q_count + QC_W'(s1_valid && s1_res) + QC_W'(s2_valid);
  assign pix_in.ready = (pending < QC_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_value[q_wr] <= s2_max;
      q_chan[q_wr]  <= s2_chan_done;
      q_frame[q_wr] <= s2_frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (q_push) q_wr <= q_wr + 1'b1;
      if (q_pop)  q_rd <= q_rd + 1'b1;
      q_count <= q_count + QC_W'(q_push) - QC_W'(q_pop);
    end
  end

  assign pool_out.valid        = (q_count != '0);
  assign pool_out.pooled_value = q_value[q_rd];
  assign pool_out.channel_done = q_chan[q_rd];
  assign pool_out.frame_done   = q_frame[q_rd];

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_queue_no_overrun: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < QC_W'(OUT_DEPTH)) || q_pop)
    else $error("result word pushed into a full output queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= QC_W'(OUT_DEPTH))
    else $error("results in flight exceed output queue depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (KW'(s1_col) < KW'(MAX_WIDTH)))
    else $error("line store written beyond its depth");

  a_frame_implies_chan: assert property (@(posedge clk) disable iff (rst)
    pool_out.valid && pool_out.frame_done |-> pool_out.channel_done)
    else $error("frame end flagged without channel end");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    accept && win_hit |=> ##1 s2_valid)
    else $error("window result lost between pipeline stages");

endmodule

// File: tb/mp3s_tb_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mp3s_tb_pkg
// Scoreboard of the strided 3x3 max pooling testbench. It mirrors the unit's
// registers, counters and three-row line store, predicts the pooled word that
// each accepted pixel causes, and compares the words that leave the unit.
// -----------------------------------------------------------------------------
package mp3s_tb_pkg;
  import mp3s_pkg::*;

  localparam int PIX_W      = 8;
  localparam int LINE_W     = 64;
  localparam int REPORT_CAP = 40;

  // indexes that decode to no register
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam logic [PIX_W-1:0] PIX_MIN = 8'h80;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'h7F;

  typedef logic [PIX_W-1:0] pixel_q_t[$];

  typedef struct packed {
    logic [PIX_W-1:0] pooled_value;
    logic             channel_done;
    logic             frame_done;
  } pool_word_t;

  class pool_scoreboard;
    // register copies
    logic [CHAN_W-1:0]   channel_count;
    logic [DIM_W-1:0]    in_height;
    logic [DIM_W-1:0]    in_width;
    logic [DIM_W-1:0]    out_height;
    logic [DIM_W-1:0]    out_width;
    logic [STRIDE_W-1:0] pool_stride;

    // position counters and line store
    logic [ROW_W-1:0]        in_row, in_col, out_row, out_col;
    logic [PHASE_W-1:0]      row_phase, col_phase;
    logic [CIDX_W-1:0]       channel_index;
    logic signed [PIX_W-1:0] line_store [3*LINE_W];

    pool_word_t expected_words[$];
    int errors;
    int words_checked;
    int pixels_taken;

    function new();
      channel_count = 1;
      in_height     = 3;
      in_width      = 3;
      out_height    = 1;
      out_width     = 1;
      pool_stride   = 1;
      in_row        = '0;
      in_col        = '0;
      out_row       = '0;
      out_col       = '0;
      row_phase     = '0;
      col_phase     = '0;
      channel_index = '0;
      foreach (line_store[i]) line_store[i] = '0;
      errors        = 0;
      words_checked = 0;
      pixels_taken  = 0;
    endfunction

    // zero reads as one, anything above the limit as the limit
    function int clamp_reg(int v, int hi);
      if (v < 1) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int frame_pixels();
      return clamp_reg(channel_count, MAX_CHANNELS) * clamp_reg(in_height, MAX_HEIGHT) *
             clamp_reg(in_width, LINE_W);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHANNEL_COUNT: channel_count = data[CHAN_W-1:0];
        CFG_IN_HEIGHT:     in_height     = data[DIM_W-1:0];
        CFG_IN_WIDTH:      in_width      = data[DIM_W-1:0];
        CFG_OUT_HEIGHT:    out_height    = data[DIM_W-1:0];
        CFG_OUT_WIDTH:     out_width     = data[DIM_W-1:0];
        CFG_POOL_STRIDE:   pool_stride   = data[STRIDE_W-1:0];
        default: ;
      endcase
    endfunction

    // store the pixel, emit the window maximum if it closes a strided window,
    // then advance the raster position
    function void note_pixel(logic [PIX_W-1:0] raw);
      int ew, eh, es, ec, col, r, c;
      bit row_live, col_live, last_in_channel;
      logic signed [PIX_W-1:0] best;
      pool_word_t word;
      ew = clamp_reg(in_width, LINE_W);
      eh = clamp_reg(in_height, MAX_HEIGHT);
      es = clamp_reg(pool_stride, MAX_STRIDE);
      ec = clamp_reg(channel_count, MAX_CHANNELS);
      col = (in_col < ew) ? in_col : ew - 1;
      row_live = in_row >= 2 && row_phase == 0 && out_row < out_height;
      col_live = in_col >= 2 && col_phase == 0 && out_col < out_width;
      pixels_taken++;

      line_store[(in_row % 3) * LINE_W + col] = raw;

      if (row_live && col_live) begin
        best = line_store[col];
        if (col >= 2) begin
          for (r = 0; r < 3; r++)
            for (c = col - 2; c <= col; c++)
              if (line_store[r * LINE_W + c] > best) best = line_store[r * LINE_W + c];
        end
        last_in_channel = (out_row + 1 == out_height) && (out_col + 1 == out_width);
        word.pooled_value = best;
        word.channel_done = last_in_channel;
        word.frame_done   = last_in_channel && (channel_index + 1 >= ec);
        expected_words.push_back(word);
        out_col++;
      end

      if (in_col >= 2) col_phase = (col_phase + 1 >= es) ? '0 : col_phase + 1;

      if (in_col + 1 >= ew) begin
        in_col    = '0;
        col_phase = '0;
        out_col   = '0;
        if (row_live) out_row++;
        if (in_row >= 2) row_phase = (row_phase + 1 >= es) ? '0 : row_phase + 1;
        if (in_row + 1 >= eh) begin
          in_row    = '0;
          row_phase = '0;
          out_row   = '0;
          channel_index = (channel_index + 1 >= ec) ? '0 : channel_index + 1;
        end else begin
          in_row++;
        end
      end else begin
        in_col++;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [PIX_W-1:0] value, logic chan_done, logic frm_done);
      pool_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("pooled word %0d with nothing expected", $signed(value)));
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (value !== want.pooled_value)
        report($sformatf("word %0d: pooled_value %0d, want %0d", words_checked,
                         $signed(value), $signed(want.pooled_value)));
      if (chan_done !== want.channel_done)
        report($sformatf("word %0d: channel_done %b, want %b", words_checked,
                         chan_done, want.channel_done));
      if (frm_done !== want.frame_done)
        report($sformatf("word %0d: frame_done %b, want %b", words_checked,
                         frm_done, want.frame_done));
    endtask
  endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench of the strided 3x3 max pooling unit. A short directed
// run covers extreme pixels, zero, oversized and masked registers and too
// narrow frames; random register settings then stream whole and broken
// frames with random gaps on the pixel side and random stalls on the result
// side, every pooled word being checked against the scoreboard.
// -----------------------------------------------------------------------------
module tb;
  import mp3s_pkg::*;
  import mp3s_tb_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int PIXEL_TARGET = 1250;
  localparam int LIMIT_NS     = 20_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mp3s_cfg_if                        cfg_bus ();
  mp3s_pix_if  #(.PIXEL_BITS(PIX_W)) pix_bus ();
  mp3s_pool_if #(.PIXEL_BITS(PIX_W)) pool_bus ();

  max_pool_3x3_strided_unit #(
    .MAX_WIDTH (LINE_W),
    .PIXEL_BITS(PIX_W)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .pix_in  (pix_bus),
    .pool_out(pool_bus)
  );

  pool_scoreboard pool_sb = new();

  int setting_count = 0;
  int hold_left     = 0;
  bit steady_out    = 1'b0;

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pixel_q_t random_pixels(int n);
    pixel_q_t q;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) q.push_back($urandom_range(0, 1) ? PIX_MIN : PIX_MAX);
      else q.push_back($urandom_range(0, 255));
    end
    return q;
  endfunction

  // result side: stall at random, with stretches of steady drain
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pool_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      pool_bus.ready <= 1'b1;
      if (!steady_out) hold_left = idle_len();
    end
    if ($urandom_range(0, 299) == 0) steady_out = !steady_out;
  end

  // sample every handshake at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)
        pool_sb.write_reg(cfg_bus.index, cfg_bus.data);
      if (pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1)
        pool_sb.note_pixel(pix_bus.pixel);
      if (pool_bus.valid === 1'b1 && pool_bus.ready === 1'b1)
        pool_sb.check_result(pool_bus.pooled_value, pool_bus.channel_done, pool_bus.frame_done);
    end
  end

  // hold the write up until it is taken; valid stays high for a following write
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] chans, ih, iw, oh, ow, stride);
    cfg_write(CFG_CHANNEL_COUNT, chans);
    cfg_write(CFG_IN_HEIGHT, ih);
    cfg_write(CFG_IN_WIDTH, iw);
    cfg_write(CFG_OUT_HEIGHT, oh);
    cfg_write(CFG_OUT_WIDTH, ow);
    cfg_write(CFG_POOL_STRIDE, stride);
    if ($urandom_range(0, 3) == 0)
      cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom_range(0, 2047));
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    setting_count++;
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] px, input int gap);
    repeat (gap) begin
      @(negedge clk);
      pix_bus.valid <= 1'b0;
    end
    @(negedge clk);
    pix_bus.valid <= 1'b1;
    pix_bus.pixel <= px;
    do @(posedge clk); while (pix_bus.ready !== 1'b1);
  endtask

  // stream the pixels, then wait until the unit has gone quiet
  task automatic run_pixels(input pixel_q_t pixels, input bit bursty);
    foreach (pixels[i]) push_pixel(pixels[i], bursty ? 0 : idle_len());
    @(negedge clk);
    pix_bus.valid <= 1'b0;
    while (pool_sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one random register setting and a stream of whole or broken frames
  task automatic random_phase();
    int s, iw, ih, oh, ow, nc, pick, frame_px, count;
    s = $urandom_range(1, 8);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      iw = $urandom_range(40, 64);
      ih = $urandom_range(3, 5);
      nc = 1;
    end else if (pick == 1) begin
      iw = $urandom_range(3, 5);
      ih = $urandom_range(40, 64);
      nc = 1;
    end else begin
      iw = $urandom_range(3, 10);
      ih = $urandom_range(3, 10);
      nc = $urandom_range(1, 3);
    end
    ow = (iw - 3) / s + 1;
    oh = (ih - 3) / s + 1;

    pick = $urandom_range(0, 99);
    if (pick >= 50 && pick < 70) begin
      ow = $urandom_range(1, ow);
      oh = $urandom_range(1, oh);
    end else if (pick >= 70 && pick < 85) begin
      case ($urandom_range(0, 5))
        0: ow = ow + $urandom_range(1, 3);
        1: oh = $urandom_range(0, 1) ? oh + $urandom_range(1, 3) : $urandom_range(0, 127);
        2: begin
          if ($urandom_range(0, 1)) ow = 0;
          else oh = 0;
        end
        3: s = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
        4: begin
          if ($urandom_range(0, 1)) iw = $urandom_range(0, 2);
          else ih = $urandom_range(0, 2);
        end
        default: nc = $urandom_range(0, 1) ? 0 : $urandom_range(1024, 2047);
      endcase
    end

    // stray upper bits that the registers must drop
    if ($urandom_range(0, 4) == 0) begin
      iw = iw | ($urandom_range(0, 15) << DIM_W);
      oh = oh | ($urandom_range(0, 15) << DIM_W);
      s  = s | ($urandom_range(0, 127) << STRIDE_W);
    end

    load_config(nc, ih, iw, oh, ow, s);

    frame_px = pool_sb.frame_pixels();
    count = frame_px * $urandom_range(1, 2);
    if (pick >= 85) count = $urandom_range(1, (2 * frame_px > 700) ? 700 : 2 * frame_px);
    else if (count > 700) count = (frame_px > 700) ? $urandom_range(1, 700) : frame_px;
    // stop at the pixel budget
    if (count > PIXEL_TARGET - pool_sb.pixels_taken)
      count = PIXEL_TARGET - pool_sb.pixels_taken;
    run_pixels(random_pixels(count), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    pixel_q_t pq;
    int s;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = '0;
    cfg_bus.data   = '0;
    pix_bus.valid  = 1'b0;
    pix_bus.pixel  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting: a single 3x3 frame of the most negative pixel
    pq = {};
    repeat (9) pq.push_back(PIX_MIN);
    run_pixels(pq, 1'b1);

    // largest pixel somewhere in an otherwise random frame
    pq = random_pixels(9);
    pq[$urandom_range(0, 8)] = PIX_MAX;
    run_pixels(pq, 1'b0);

    // all registers zero: every pixel is a one-pixel channel, no words
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, '0);
    load_config(0, 0, 0, 0, 0, 0);
    run_pixels(random_pixels(3), 1'b0);

    // oversized channel count and stride, sizes with upper bits to drop
    load_config(11'h7FF, 11'h783, 11'h783, 1, 1, 11'h00F);
    run_pixels(random_pixels(9), 1'b0);

    // frame too narrow to close any window
    load_config(1, 3, 2, 1, 1, 1);
    run_pixels(random_pixels(6), 1'b0);

    // full-width frame so that every line store entry holds a pixel
    s = $urandom_range(1, 8);
    load_config(1, 3, LINE_W, 1, (LINE_W - 3) / s + 1, s);
    run_pixels(random_pixels(3 * LINE_W), 1'b0);

    while (pool_sb.pixels_taken < PIXEL_TARGET) random_phase();

    if (pool_sb.pending() > 0)
      pool_sb.report($sformatf("%0d pooled words never arrived", pool_sb.pending()));
    $display("Streamed %0d pixels under %0d register settings; %0d pooled words compared.",
             pool_sb.pixels_taken, setting_count, pool_sb.words_checked);
    $display("Mismatches found: %0d", pool_sb.errors);
    if (pool_sb.errors == 0) begin
      $display("** max_pool_3x3_strided_unit: PASSED **");
    end else begin
      $display("** max_pool_3x3_strided_unit: FAILED **");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #(LIMIT_NS);
    $display("Run stopped by the time limit with %0d pooled words outstanding",
             pool_sb.pending());
    $display("** max_pool_3x3_strided_unit: FAILED **");
    $finish;
  end

endmodule
